// File: rtl/pgsc_pkg.sv
// Shared constants, codes and controller/datapath interface types of the gap speed controller.
package pgsc_pkg;

  localparam int PATH_DEPTH = 1024;
  localparam int IDX_W      = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int CNT_W      = $clog2(PATH_DEPTH + 1);
  localparam int NEAR_W     = 10;
  localparam int DATA_W     = 32;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_USE_LEADER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_DOWN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_UP       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FLOOR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CEILING = 3'd6;

  localparam logic IN_CMD_LOAD = 1'b0;
  localparam logic IN_CMD_TICK = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_ERR,
    ST_MUL,
    ST_SUM,
    ST_LIM,
    ST_CLAMP,
    ST_DONE
  } pgsc_state_e;

  typedef struct packed {
    logic load_wr;
    logic tick_start;
    logic scan_rd;
    logic fetch;
    logic err_en;
    logic mul_en;
    logic sum_en;
    logic lim_en;
    logic clamp_en;
    logic out_load;
  } pgsc_cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_last;
    logic pipe_busy;
  } pgsc_status_t;

endpackage

// File: rtl/pgsc_ctrl.sv
// Sequencing state machine of the gap speed controller: handshakes and stage commands.
module pgsc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  cmd_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  pgsc_pkg::pgsc_status_t sts_i,
  output pgsc_pkg::pgsc_cmd_t    cmd_o
);
  import pgsc_pkg::*;

  pgsc_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;
  logic        out_free;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (cmd_i == IN_CMD_TICK)) begin
          state_d = sts_i.empty ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) state_d = ST_FETCH;
      end
      ST_FETCH: state_d = ST_ERR;
      ST_ERR:   state_d = ST_MUL;
      ST_MUL:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_LIM;
      ST_LIM:   state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o            = '0;
    cmd_o.load_wr    = accept && (cmd_i == IN_CMD_LOAD);
    cmd_o.tick_start = accept && (cmd_i == IN_CMD_TICK);
    in_stall_o       = (state_q != ST_IDLE);
    out_valid_d      = out_valid_q && out_stall_i;
    case (state_q)
      ST_SCAN:  cmd_o.scan_rd  = 1'b1;
      ST_FETCH: cmd_o.fetch    = 1'b1;
      ST_ERR:   cmd_o.err_en   = 1'b1;
      ST_MUL:   cmd_o.mul_en   = 1'b1;
      ST_SUM:   cmd_o.sum_en   = 1'b1;
      ST_LIM:   cmd_o.lim_en   = 1'b1;
      ST_CLAMP: cmd_o.clamp_en = 1'b1;
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over an untaken result");

  a_empty_tick_skips_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.tick_start && sts_i.empty) |=> (state_q == ST_DONE))
    else $error("empty path tick did not go straight to result");

  a_scan_needs_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !sts_i.empty)
    else $error("scan running over an empty path");

  a_fetch_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |-> !sts_i.pipe_busy)
    else $error("nearest point fetched before distance pipe drained");
`endif

endmodule

// File: rtl/pgsc_dpath.sv
// Datapath of the gap speed controller: path stores, distance pipe, control law, result register.
module pgsc_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pgsc_pkg::pgsc_cmd_t                 cmd_i,
  output pgsc_pkg::pgsc_status_t              sts_o,
  input  logic                                cfg_we_i,
  input  logic [pgsc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pgsc_pkg::DATA_W-1:0]         cfg_data_i,
  input  logic signed [pgsc_pkg::DATA_W-1:0]  pos_x_i,
  input  logic signed [pgsc_pkg::DATA_W-1:0]  pos_y_i,
  input  logic signed [pgsc_pkg::DATA_W-1:0]  arc_s_i,
  input  logic                                first_point_i,
  input  logic signed [pgsc_pkg::DATA_W-1:0]  front_speed_i,
  input  logic signed [pgsc_pkg::DATA_W-1:0]  leader_speed_i,
  output logic signed [pgsc_pkg::DATA_W-1:0]  speed_cmd_o,
  output logic signed [pgsc_pkg::DATA_W-1:0]  gap_error_o,
  output logic [pgsc_pkg::NEAR_W-1:0]         nearest_index_o,
  output logic                                path_empty_o
);
  import pgsc_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // configuration
  logic               use_leader_q;
  logic [23:0]        gain_q;
  logic [30:0]        spacing_q;
  logic [30:0]        step_down_q;
  logic [30:0]        step_up_q;
  logic signed [31:0] floor_q;
  logic signed [31:0] ceil_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_leader_q <= 1'b0;
      gain_q       <= 24'd65536;
      spacing_q    <= 31'd65536;
      step_down_q  <= 31'd6554;
      step_up_q    <= 31'd6554;
      floor_q      <= 32'sd0;
      ceil_q       <= 32'sd131072;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_USE_LEADER:    use_leader_q <= cfg_data_i[0];
        CFG_GAIN:          gain_q       <= cfg_data_i[23:0];
        CFG_SPACING:       spacing_q    <= cfg_data_i[30:0];
        CFG_STEP_DOWN:     step_down_q  <= cfg_data_i[30:0];
        CFG_STEP_UP:       step_up_q    <= cfg_data_i[30:0];
        CFG_SPEED_FLOOR:   floor_q      <= $signed(cfg_data_i);
        CFG_SPEED_CEILING: ceil_q       <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // path fill and last arc length
  logic [CNT_W-1:0]   count_q;
  logic [IDX_W-1:0]   wr_addr;
  logic               wr_en;
  logic signed [31:0] s_last_q;

  assign wr_addr = first_point_i ? '0 : count_q[IDX_W-1:0];
  assign wr_en   = cmd_i.load_wr && (first_point_i || (count_q < CNT_W'(PATH_DEPTH)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (wr_en) begin
      count_q <= first_point_i ? CNT_W'(1) : count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) s_last_q <= arc_s_i;
  end

  // tick operands
  logic signed [31:0] ego_x_q, ego_y_q, ref_q;
  logic               tick_empty_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_start) begin
      ego_x_q      <= pos_x_i;
      ego_y_q      <= pos_y_i;
      ref_q        <= use_leader_q ? leader_speed_i : front_speed_i;
      tick_empty_q <= (count_q == '0);
    end
  end

  // path stores
  logic [31:0]        x_mem [PATH_DEPTH];
  logic [31:0]        y_mem [PATH_DEPTH];
  logic [31:0]        s_mem [PATH_DEPTH];
  logic [IDX_W-1:0]   addr_q;
  logic [IDX_W-1:0]   best_q;
  logic signed [31:0] x_rd_q, y_rd_q, s_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) x_mem[wr_addr] <= pos_x_i;
    if (cmd_i.scan_rd) x_rd_q <= x_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) y_mem[wr_addr] <= pos_y_i;
    if (cmd_i.scan_rd) y_rd_q <= y_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) s_mem[wr_addr] <= arc_s_i;
    if (cmd_i.fetch) s_rd_q <= s_mem[best_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (cmd_i.tick_start) begin
      addr_q <= '0;
    end else if (cmd_i.scan_rd) begin
      addr_q <= addr_q + IDX_W'(1);
    end
  end

  // distance pipe: read, abs diff, square, compare
  logic               v1_q, v2_q, v3_q;
  logic [IDX_W-1:0]   idx1_q, idx2_q, idx3_q;
  logic [31:0]        dx_q, dy_q;
  logic [63:0]        sqx_q, sqy_q;
  logic [64:0]        sq_dist;
  logic [64:0]        best_dist_q;
  logic signed [32:0] diff_x, diff_y;

  assign diff_x  = {x_rd_q[31], x_rd_q} - {ego_x_q[31], ego_x_q};
  assign diff_y  = {y_rd_q[31], y_rd_q} - {ego_y_q[31], ego_y_q};
  assign sq_dist = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.scan_rd;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= addr_q;
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    dx_q   <= diff_x[32] ? 32'(-diff_x) : diff_x[31:0];
    dy_q   <= diff_y[32] ? 32'(-diff_y) : diff_y[31:0];
    sqx_q  <= 64'(dx_q) * 64'(dx_q);
    sqy_q  <= 64'(dy_q) * 64'(dy_q);
    // first point seeds the search; later ones replace only on strictly smaller
    if (v3_q && ((idx3_q == '0) || (sq_dist < best_dist_q))) begin
      best_dist_q <= sq_dist;
      best_q      <= idx3_q;
    end
  end

  // control law
  logic signed [33:0] err_full, lo_d, hi_d;
  logic signed [31:0] err_q;
  logic signed [33:0] lo_q, hi_q;
  logic signed [24:0] gain_s;
  logic signed [56:0] prod_q;
  logic signed [41:0] sum_full;
  logic signed [31:0] sum_q;
  logic signed [33:0] sum_x, floor_x, ceil_x;
  logic signed [33:0] lim_q;
  logic signed [31:0] fin_q;
  logic signed [31:0] last_q;

  assign err_full = $signed({{2{s_last_q[31]}}, s_last_q}) - $signed({{2{s_rd_q[31]}}, s_rd_q})
                  - $signed({3'b0, spacing_q});
  assign lo_d     = $signed({{2{last_q[31]}}, last_q}) - $signed({3'b0, step_down_q});
  assign hi_d     = $signed({{2{last_q[31]}}, last_q}) + $signed({3'b0, step_up_q});
  assign gain_s   = $signed({1'b0, gain_q});
  // arithmetic shift by 16 rounds toward minus infinity
  assign sum_full = $signed({{10{ref_q[31]}}, ref_q}) + $signed({prod_q[56], prod_q[56:16]});
  assign sum_x    = $signed({{2{sum_q[31]}}, sum_q});
  assign floor_x  = $signed({{2{floor_q[31]}}, floor_q});
  assign ceil_x   = $signed({{2{ceil_q[31]}}, ceil_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.err_en) begin
      err_q <= sat32(64'(err_full));
      lo_q  <= lo_d;
      hi_q  <= hi_d;
    end
    if (cmd_i.mul_en) prod_q <= 57'(err_q) * 57'(gain_s);
    if (cmd_i.sum_en) sum_q <= sat32(64'(sum_full));
    if (cmd_i.lim_en) begin
      if (sum_x < lo_q) begin
        lim_q <= lo_q;
      end else if (sum_x > hi_q) begin
        lim_q <= hi_q;
      end else begin
        lim_q <= sum_x;
      end
    end
    if (cmd_i.clamp_en) begin
      if (lim_q < floor_x) begin
        fin_q <= floor_q;
      end else if (lim_q > ceil_x) begin
        fin_q <= ceil_q;
      end else begin
        fin_q <= lim_q[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (cmd_i.out_load && !tick_empty_q) begin
      last_q <= fin_q;
    end
  end

  // result register
  logic [IDX_W+NEAR_W-1:0] best_ext;

  assign best_ext = {{NEAR_W{1'b0}}, best_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (tick_empty_q) begin
        speed_cmd_o     <= '0;
        gap_error_o     <= '0;
        nearest_index_o <= '0;
        path_empty_o    <= 1'b1;
      end else begin
        speed_cmd_o     <= fin_q;
        gap_error_o     <= err_q;
        nearest_index_o <= best_ext[NEAR_W-1:0];
        path_empty_o    <= 1'b0;
      end
    end
  end

  assign sts_o.empty     = (count_q == '0);
  assign sts_o.scan_last = (CNT_W'(addr_q) == (count_q - CNT_W'(1)));
  assign sts_o.pipe_busy = v1_q || v2_q || v3_q;

endmodule

// File: rtl/path_gap_speed_controller.sv
// Top level of the path gap speed controller: controller and datapath.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------------
//  input   | in        | in_valid_i / in_stall_o   | cmd, pos_x, pos_y, arc_s, first_point,
//          |           |                           | front_speed, leader_speed
//  result  | out       | out_valid_o / out_stall_i | speed_cmd, gap_error, nearest_index,
//          |           |                           | path_empty
//  config  | in        | cfg_we_i (no handshake)   | cfg_idx_i, cfg_data_i
//
// A load transaction gives no result, and loads can follow back to back.
// A tick with N stored points sends N path reads, one a cycle, through a four-stage distance
// pipe (read, difference, square, compare), then one read of the matched arc length and five
// control-law stages. A tick on an empty path skips the pipe and the control-law stages.
// Reset clears the point count and last speed and loads the configuration defaults; the path
// stores hold whatever they held and only entries below the count are read, so no clearing pass.
// A finished result waits in the output register under stall; the block takes new loads
// meanwhile, and a following tick holds in its last stage until the register frees.
module path_gap_speed_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                cmd_i,
  input  logic signed [pgsc_pkg::DATA_W-1:0]  pos_x_i,
  input  logic signed [pgsc_pkg::DATA_W-1:0]  pos_y_i,
  input  logic signed [pgsc_pkg::DATA_W-1:0]  arc_s_i,
  input  logic                                first_point_i,
  input  logic signed [pgsc_pkg::DATA_W-1:0]  front_speed_i,
  input  logic signed [pgsc_pkg::DATA_W-1:0]  leader_speed_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pgsc_pkg::DATA_W-1:0]  speed_cmd_o,
  output logic signed [pgsc_pkg::DATA_W-1:0]  gap_error_o,
  output logic [pgsc_pkg::NEAR_W-1:0]         nearest_index_o,
  output logic                                path_empty_o,
  input  logic                                cfg_we_i,
  input  logic [pgsc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pgsc_pkg::DATA_W-1:0]         cfg_data_i
);
  import pgsc_pkg::*;

  // command and status between sequencer and datapath
  pgsc_cmd_t    cmd;
  pgsc_status_t sts;

  // sequencer: accept transactions, step the scan and law stages, hand over the result
  pgsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: path stores, nearest-point search, gap law, rate limit and clamp
  pgsc_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .arc_s_i         (arc_s_i),
    .first_point_i   (first_point_i),
    .front_speed_i   (front_speed_i),
    .leader_speed_i  (leader_speed_i),
    .speed_cmd_o     (speed_cmd_o),
    .gap_error_o     (gap_error_o),
    .nearest_index_o (nearest_index_o),
    .path_empty_o    (path_empty_o)
  );

endmodule

// File: tb/speed_command_checker.sv
// Checker for the path gap speed controller: watches the channels, predicts each tick and compares.
`timescale 1ns / 1ps

module speed_command_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic                                cmd_i,
  input  logic signed [pgsc_pkg::DATA_W-1:0]  pos_x_i,
  input  logic signed [pgsc_pkg::DATA_W-1:0]  pos_y_i,
  input  logic signed [pgsc_pkg::DATA_W-1:0]  arc_s_i,
  input  logic                                first_point_i,
  input  logic signed [pgsc_pkg::DATA_W-1:0]  front_speed_i,
  input  logic signed [pgsc_pkg::DATA_W-1:0]  leader_speed_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic signed [pgsc_pkg::DATA_W-1:0]  speed_cmd_i,
  input  logic signed [pgsc_pkg::DATA_W-1:0]  gap_error_i,
  input  logic [pgsc_pkg::NEAR_W-1:0]         nearest_index_i,
  input  logic                                path_empty_i,
  input  logic                                cfg_we_i,
  input  logic [pgsc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pgsc_pkg::DATA_W-1:0]         cfg_data_i,
  output int                                  pending_o,
  output int                                  mismatches_o,
  output int                                  checked_o
);
  import pgsc_pkg::*;

  localparam longint S32_MAX   = 64'sd2147483647;
  localparam longint S32_MIN   = -64'sd2147483648;
  localparam int     PRINT_CAP = 40;
  // Room for expected results; the block never holds more than two
  localparam int     EXP_DEPTH = 16;

  typedef struct packed {
    logic signed [DATA_W-1:0] speed;
    logic signed [DATA_W-1:0] gap_err;
    logic [NEAR_W-1:0]        near;
    logic                     empty;
  } speed_result_t;

  speed_result_t expected_speeds [EXP_DEPTH];
  int unsigned   exp_wr_ptr;
  int unsigned   exp_rd_ptr;
  speed_result_t oldest;

  // Own copy of the stored path and the controller state
  logic signed [DATA_W-1:0] path_x [PATH_DEPTH];
  logic signed [DATA_W-1:0] path_y [PATH_DEPTH];
  logic signed [DATA_W-1:0] path_s [PATH_DEPTH];
  int unsigned              stored_points;
  longint                   last_cmd;

  logic                     follow_leader;
  logic [23:0]              gain_q;
  logic [30:0]              spacing_q;
  logic [30:0]              step_down_q;
  logic [30:0]              step_up_q;
  logic signed [DATA_W-1:0] floor_q;
  logic signed [DATA_W-1:0] ceiling_q;

  function automatic longint clip32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // Nearest point, gap error, control law, rate limit and clamp; updates last_cmd unless the path is empty
  function automatic speed_result_t predict_tick(input logic signed [DATA_W-1:0] ex,
                                                 input logic signed [DATA_W-1:0] ey,
                                                 input logic signed [DATA_W-1:0] fs,
                                                 input logic signed [DATA_W-1:0] ls);
    int unsigned   i;
    int unsigned   best;
    logic [64:0]   dx;
    logic [64:0]   dy;
    logic [64:0]   sq_dist;
    logic [64:0]   best_dist;
    longint        d;
    longint        gap;
    longint        err;
    longint        target_speed;
    longint        cmdv;
    longint        lo;
    longint        hi;
    speed_result_t r;
    if (stored_points == 0) begin
      r.speed   = '0;
      r.gap_err = '0;
      r.near    = '0;
      r.empty   = 1'b1;
      return r;
    end
    best      = 0;
    best_dist = '1;
    for (i = 0; i < stored_points; i++) begin
      d = longint'(path_x[i]) - longint'(ex);
      if (d < 0) d = -d;
      dx = {1'b0, d};
      d = longint'(path_y[i]) - longint'(ey);
      if (d < 0) d = -d;
      dy = {1'b0, d};
      sq_dist = dx * dx + dy * dy;
      if (i == 0 || sq_dist < best_dist) begin
        best_dist = sq_dist;
        best      = i;
      end
    end
    gap          = longint'(path_s[stored_points-1]) - longint'(path_s[best]);
    err          = clip32(gap - longint'(spacing_q));
    target_speed = follow_leader ? longint'(ls) : longint'(fs);
    cmdv         = clip32(target_speed + ((err * longint'(gain_q)) >>> 16));
    lo = last_cmd - longint'(step_down_q);
    hi = last_cmd + longint'(step_up_q);
    if (cmdv < lo) cmdv = lo;
    else if (cmdv > hi) cmdv = hi;
    if (cmdv < longint'(floor_q)) cmdv = longint'(floor_q);
    else if (cmdv > longint'(ceiling_q)) cmdv = longint'(ceiling_q);
    last_cmd  = cmdv;
    r.speed   = cmdv[31:0];
    r.gap_err = err[31:0];
    r.near    = best[NEAR_W-1:0];
    r.empty   = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches_o++;
    if (mismatches_o <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_wr_ptr    = 0;
      exp_rd_ptr    = 0;
      stored_points = 0;
      last_cmd      = 0;
      follow_leader = 1'b0;
      gain_q        = 24'd65536;
      spacing_q     = 31'd65536;
      step_down_q   = 31'd6554;
      step_up_q     = 31'd6554;
      floor_q       = 32'sd0;
      ceiling_q     = 32'sd131072;
      mismatches_o  = 0;
      checked_o     = 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_USE_LEADER:    follow_leader = cfg_data_i[0];
          CFG_GAIN:          gain_q        = cfg_data_i[23:0];
          CFG_SPACING:       spacing_q     = cfg_data_i[30:0];
          CFG_STEP_DOWN:     step_down_q   = cfg_data_i[30:0];
          CFG_STEP_UP:       step_up_q     = cfg_data_i[30:0];
          CFG_SPEED_FLOOR:   floor_q       = cfg_data_i;
          CFG_SPEED_CEILING: ceiling_q     = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (exp_wr_ptr == exp_rd_ptr) begin
          report_mismatch($sformatf("result with nothing expected (speed_cmd %0d)",
                                    speed_cmd_i));
        end else begin
          oldest = expected_speeds[exp_rd_ptr % EXP_DEPTH];
          exp_rd_ptr++;
          checked_o++;
          if (speed_cmd_i !== oldest.speed)
            report_mismatch($sformatf("speed_cmd got %0d want %0d", speed_cmd_i, oldest.speed));
          if (gap_error_i !== oldest.gap_err)
            report_mismatch($sformatf("gap_error got %0d want %0d", gap_error_i, oldest.gap_err));
          if (nearest_index_i !== oldest.near)
            report_mismatch($sformatf("nearest_index got %0d want %0d",
                                      nearest_index_i, oldest.near));
          if (path_empty_i !== oldest.empty)
            report_mismatch($sformatf("path_empty got %0b want %0b", path_empty_i, oldest.empty));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (cmd_i == IN_CMD_LOAD) begin
          if (first_point_i) stored_points = 0;
          if (stored_points < PATH_DEPTH) begin
            path_x[stored_points] = pos_x_i;
            path_y[stored_points] = pos_y_i;
            path_s[stored_points] = arc_s_i;
            stored_points++;
          end
        end else if (exp_wr_ptr - exp_rd_ptr >= EXP_DEPTH) begin
          report_mismatch("more ticks outstanding than the block can hold");
        end else begin
          expected_speeds[exp_wr_ptr % EXP_DEPTH] = predict_tick(pos_x_i, pos_y_i,
                                                                 front_speed_i, leader_speed_i);
          exp_wr_ptr++;
        end
      end
      pending_o <= int'(exp_wr_ptr - exp_rd_ptr);
    end
  end

endmodule

// File: tb/testbench.sv
// Top of the gap speed controller testbench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps

module testbench;
  import pgsc_pkg::*;

  // Cycles to let pass after the last result before touching the registers
  localparam int IDLE_PAD     = 32;
  // Length of the long receiver hold-off that backs the block up
  localparam int HOLD_CYCLES  = 400;
  // Transactions per random phase
  localparam int PHASE_ITEMS  = 48;
  // Most points in one path load of the random phases; keeps ticks short
  localparam int SHORT_PATH   = 24;
  // Loads in the long-path phase
  localparam int LONG_PATH    = 40;
  // Bound on the final drain
  localparam int DRAIN_LIMIT  = 50000;
  // Register index that maps to nothing; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     cmd;
  logic signed [DATA_W-1:0] pos_x;
  logic signed [DATA_W-1:0] pos_y;
  logic signed [DATA_W-1:0] arc_s;
  logic                     first_point;
  logic signed [DATA_W-1:0] front_speed;
  logic signed [DATA_W-1:0] leader_speed;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] speed_cmd;
  logic signed [DATA_W-1:0] gap_error;
  logic [NEAR_W-1:0]        nearest_index;
  logic                     path_empty;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_idx;
  logic [DATA_W-1:0]        cfg_data;

  int pending;
  int mismatches;
  int checked;

  // Stimulus bookkeeping
  bit          quiet_tail       = 1'b0;
  bit          hold_request     = 1'b0;
  int          sent_items       = 0;
  int          ticks_sent       = 0;
  int          settings_applied = 0;
  logic [31:0] shadow_x [PATH_DEPTH];
  logic [31:0] shadow_y [PATH_DEPTH];
  int          shadow_count     = 0;

  path_gap_speed_controller dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .cmd_i           (cmd),
    .pos_x_i         (pos_x),
    .pos_y_i         (pos_y),
    .arc_s_i         (arc_s),
    .first_point_i   (first_point),
    .front_speed_i   (front_speed),
    .leader_speed_i  (leader_speed),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .speed_cmd_o     (speed_cmd),
    .gap_error_o     (gap_error),
    .nearest_index_o (nearest_index),
    .path_empty_o    (path_empty),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  speed_command_checker u_speed_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .cmd_i           (cmd),
    .pos_x_i         (pos_x),
    .pos_y_i         (pos_y),
    .arc_s_i         (arc_s),
    .first_point_i   (first_point),
    .front_speed_i   (front_speed),
    .leader_speed_i  (leader_speed),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .speed_cmd_i     (speed_cmd),
    .gap_error_i     (gap_error),
    .nearest_index_i (nearest_index),
    .path_empty_i    (path_empty),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .pending_o       (pending),
    .mismatches_o    (mismatches),
    .checked_o       (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop: the slowest legal run is far below this
  initial begin
    #10_000_000;
    $display("run exceeded its time limit with %0d results outstanding", pending);
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: random stall bursts, free stretches, one long hold-off on request,
  // and no stalling at all once the quiet tail starts
  initial begin
    int held;
    out_stall <= 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall   <= 1'b1;
        held         = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
      end else if (quiet_tail) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Mix of extremes, small signed values and full random words
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h0000_0001;
      5, 6:    return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  // Speeds mostly within +-20 m/s, so the rate limits and clamps get exercised
  function automatic logic [31:0] pick_speed();
    if ($urandom_range(0, 4) == 0) return pick_word();
    return $urandom_range(0, 40 << 16) - (20 << 16);
  endfunction

  // Offer one transaction and hold it until accepted. Valid is only lowered
  // when an idle burst is inserted, so it never drops and rises in one step.
  task automatic offer(input logic c, input logic [31:0] x, input logic [31:0] y,
                       input logic [31:0] s, input logic fp,
                       input logic [31:0] fs, input logic [31:0] ls);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= c;
    pos_x        <= x;
    pos_y        <= y;
    arc_s        <= s;
    first_point  <= fp;
    front_speed  <= fs;
    leader_speed <= ls;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    if (c == IN_CMD_TICK) begin
      ticks_sent++;
    end else begin
      // Mirror the stored path, for aiming the ego position
      if (fp) shadow_count = 0;
      if (shadow_count < PATH_DEPTH) begin
        shadow_x[shadow_count] = x;
        shadow_y[shadow_count] = y;
        shadow_count++;
      end
    end
  endtask

  task automatic load_point(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] s, input logic fp);
    offer(IN_CMD_LOAD, x, y, s, fp, $urandom, $urandom);
  endtask

  task automatic tick(input logic [31:0] x, input logic [31:0] y,
                      input logic [31:0] fs, input logic [31:0] ls);
    offer(IN_CMD_TICK, x, y, $urandom, 1'($urandom_range(0, 1)), fs, ls);
  endtask

  // Tick near a stored point most of the time, anywhere otherwise
  task automatic aimed_tick();
    int pick;
    if (shadow_count == 0 || $urandom_range(0, 5) == 0) begin
      tick(pick_word(), pick_word(), pick_speed(), pick_speed());
    end else begin
      pick = $urandom_range(0, shadow_count - 1);
      tick(shadow_x[pick] + $urandom_range(0, 16) - 8,
           shadow_y[pick] + $urandom_range(0, 16) - 8, pick_speed(), pick_speed());
    end
  endtask

  // Drop valid and wait until every expected result is in, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (IDLE_PAD) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  // Write every register; bits above each register's width carry junk
  task automatic apply_settings(input logic ul, input logic [23:0] g, input logic [30:0] sp,
                                input logic [30:0] sd, input logic [30:0] su,
                                input logic [31:0] fl, input logic [31:0] ce);
    logic [31:0] junk;
    junk = $urandom;
    wait_idle();
    cfg_write(CFG_USE_LEADER, {junk[31:1], ul});
    cfg_write(CFG_GAIN, {junk[31:24], g});
    cfg_write(CFG_UNUSED_IDX, $urandom);
    cfg_write(CFG_SPACING, {junk[31], sp});
    cfg_write(CFG_STEP_DOWN, {junk[30], sd});
    cfg_write(CFG_STEP_UP, {junk[29], su});
    cfg_write(CFG_SPEED_FLOOR, fl);
    cfg_write(CFG_SPEED_CEILING, ce);
    settings_applied++;
  endtask

  task automatic apply_random_settings();
    logic        ul;
    logic [23:0] g;
    logic [30:0] sp;
    logic [30:0] sd;
    logic [30:0] su;
    logic [31:0] fl;
    logic [31:0] ce;
    ul = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0:       g = '0;
      1:       g = '1;
      2:       g = 24'($urandom_range(0, 24'h03_FFFF));
      default: g = 24'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       sp = '0;
      1:       sp = '1;
      2:       sp = 31'($urandom_range(0, 20 << 16));
      default: sp = 31'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       sd = '0;
      1:       sd = '1;
      2:       sd = 31'($urandom);
      default: sd = 31'($urandom_range(0, 2 << 16));
    endcase
    case ($urandom_range(0, 4))
      0:       su = '0;
      1:       su = '1;
      2:       su = 31'($urandom);
      default: su = 31'($urandom_range(0, 2 << 16));
    endcase
    case ($urandom_range(0, 3))
      0: begin
        fl = 32'h8000_0000;
        ce = 32'h7FFF_FFFF;
      end
      1: begin
        fl = $urandom;
        ce = $urandom;
      end
      2: begin
        // Inverted window: floor above ceiling
        fl = $urandom_range(1, 10 << 16);
        ce = -$urandom_range(0, 10 << 16);
      end
      default: begin
        fl = -$urandom_range(0, 40 << 16);
        ce = $urandom_range(0, 40 << 16);
      end
    endcase
    apply_settings(ul, g, sp, sd, su, fl, ce);
  endtask

  // Mostly well-formed path loads followed by ticks, with noise loads,
  // stray ticks and the odd pause until the results are all in
  task automatic run_random_phase(input int items);
    int          goal;
    int          roll;
    int          k;
    int          j;
    int          style;
    logic [31:0] bx;
    logic [31:0] by;
    logic [31:0] s_acc;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] s;
    goal = sent_items + items;
    while (sent_items < goal) begin
      roll = $urandom_range(0, 19);
      if (roll < 14) begin
        k     = $urandom_range(1, SHORT_PATH);
        if (k > goal - sent_items) k = goal - sent_items;
        style = $urandom_range(0, 2);
        bx    = $urandom;
        by    = $urandom;
        s_acc = pick_word();
        for (j = 0; j < k; j++) begin
          case (style)
            0: begin
              x = pick_word();
              y = pick_word();
            end
            1: begin
              x = bx + $urandom_range(0, 8191) - 4096;
              y = by + $urandom_range(0, 8191) - 4096;
            end
            default: begin
              // Coarse grid, so equal distances and duplicate points turn up
              x = $urandom_range(0, 3) << 16;
              y = $urandom_range(0, 3) << 16;
            end
          endcase
          if ($urandom_range(0, 7) == 0) begin
            s = pick_word();
          end else begin
            s_acc = s_acc + $urandom_range(0, 3 << 16);
            s     = s_acc;
          end
          load_point(x, y, s, j == 0);
        end
        repeat ($urandom_range(1, 6)) aimed_tick();
      end else if (roll < 17) begin
        load_point(pick_word(), pick_word(), pick_word(), $urandom_range(0, 5) == 0);
      end else if (roll < 19) begin
        tick(pick_word(), pick_word(), pick_speed(), pick_speed());
      end else if (!quiet_tail) begin
        wait_idle();
      end
    end
  endtask

  initial begin
    int j;
    int guard;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    cmd          <= IN_CMD_LOAD;
    pos_x        <= '0;
    pos_y        <= '0;
    arc_s        <= '0;
    first_point  <= 1'b0;
    front_speed  <= '0;
    leader_speed <= '0;
    cfg_we       <= 1'b0;
    cfg_idx      <= CFG_USE_LEADER;
    cfg_data     <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed part, under the reset configuration.
    // Tick before any point is stored: zero command, empty flag, last speed kept.
    tick(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    // Corner points, then a duplicate pair so the first of equal distances must win
    load_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    load_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    load_point(32'h0005_0000, 32'h0005_0000, 32'h000A_0000, 1'b0);
    load_point(32'h0005_0000, 32'h0005_0000, 32'h0014_0000, 1'b0);
    load_point(32'hFFFD_0000, 32'h0007_0000, 32'h001E_0000, 1'b0);
    // Far corner: squared distances overflow 64 bits; gap error saturates
    tick(32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000);
    tick(32'h0005_0000, 32'h0005_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    tick(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    tick(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
    // Restart the path with a single point
    load_point(32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 1'b1);
    tick(32'h0000_0001, 32'h0000_0002, 32'h0000_0000, 32'h0000_0000);
    tick(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);

    // Reset values written back, then a longer path load than the random phases make
    apply_settings(1'b0, 24'd65536, 31'd65536, 31'd6554, 31'd6554, 32'd0, 32'd131072);
    for (j = 0; j < LONG_PATH; j++) load_point($urandom, $urandom, $urandom, j == 0);
    tick(shadow_x[LONG_PATH-1], shadow_y[LONG_PATH-1], pick_speed(), pick_speed());
    tick(shadow_x[LONG_PATH/2], shadow_y[LONG_PATH/2], pick_speed(), pick_speed());
    aimed_tick();
    aimed_tick();
    // Restart from the long path
    load_point(pick_word(), pick_word(), pick_word(), 1'b1);
    aimed_tick();

    // No rate limit, no clamp, leader speed, zero gain and spacing
    apply_settings(1'b1, 24'd0, 31'd0, '1, '1, 32'h8000_0000, 32'h7FFF_FFFF);
    run_random_phase(PHASE_ITEMS);
    // Largest gain and spacing, zero steps: the command is pinned to the last speed
    apply_settings(1'b0, '1, '1, 31'd0, 31'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    run_random_phase(PHASE_ITEMS);
    // Floor above ceiling
    apply_settings(1'b0, 24'h04_0000, 31'd65536, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                   32'h000F_4240, 32'hFFF0_BDC0);
    run_random_phase(PHASE_ITEMS);

    // Long receiver hold-off while ticks keep coming: the block fills and stalls its input
    apply_random_settings();
    load_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
    load_point(32'h0002_0000, 32'h0001_0000, 32'h0002_0000, 1'b0);
    load_point(32'h0003_0000, 32'h0002_0000, 32'h0003_0000, 1'b0);
    hold_request = 1'b1;
    repeat (10) aimed_tick();
    run_random_phase(30);

    repeat (5) begin
      apply_random_settings();
      run_random_phase(PHASE_ITEMS);
    end

    // Quiet tail: neither side idles
    apply_random_settings();
    quiet_tail = 1'b1;
    run_random_phase(60);

    // Drain, with a bound, and give the block time to settle
    in_valid <= 1'b0;
    guard = 0;
    @(posedge clk);
    while (pending != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (IDLE_PAD) @(posedge clk);

    if (pending != 0) $display("%0d expected results never arrived", pending);
    $display("Sent %0d transactions (%0d ticks) under %0d register settings; %0d results checked.",
             sent_items, ticks_sent, settings_applied, checked);
    $display("Covered empty path, equal distances, path restarts, %s",
             "inverted clamp window and a long output hold-off.");
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/pgsc_pkg.sv
rtl/pgsc_ctrl.sv
rtl/pgsc_dpath.sv
rtl/path_gap_speed_controller.sv
tb/speed_command_checker.sv
tb/testbench.sv
